// ===== sv/clock_synth_divider_writer_unit_defines.svh =====
// Assertion macros used by the checker file of the divider writer.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef CLOCK_SYNTH_DIVIDER_WRITER_UNIT_DEFINES_SVH
`define CLOCK_SYNTH_DIVIDER_WRITER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSDW_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSDW_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/csdw_pkg.sv =====
`default_nettype none

package csdw_pkg;

   // Field widths.
   localparam int IDX_W    = 2;
   localparam int FREQ_W   = 28;
   localparam int XTAL_W   = 25;
   localparam int BYTE_W   = 8;

   // Serial divider: 30-bit dividend, 28-bit divisor, one quotient bit per cycle.
   localparam int DVD_W     = 30;
   localparam int DVS_W     = 28;
   localparam int DIV_CNT_W = $clog2(DVD_W);

   // Serial multiplier: multiplier bits consumed one per cycle.
   localparam int MCAND_W   = 30;
   localparam int MPLIER_W  = 10;
   localparam int MUL_CNT_W = $clog2(MPLIER_W);

   // Intermediate widths.
   localparam int QDIV_W    = 17;
   localparam int RSH_W     = 3;
   localparam int FRAC_SH   = 5;
   localparam int C_W       = XTAL_W - FRAC_SH;
   localparam int A_W       = 6;
   localparam int F_W       = 8;
   localparam int P1_W      = 18;
   localparam int P2_W      = 20;
   localparam int CNT_W     = 5;

   // Frequency limits and fixed values.
   localparam logic [DVD_W-1:0]  VCO_MAX_HZ = 30'd900000000;
   localparam logic [QDIV_W-1:0] DIV_MAX    = 17'd900;
   localparam logic [FREQ_W-1:0] FREQ_MIN   = 28'd8000;
   localparam logic [FREQ_W-1:0] FREQ_MAX   = 28'd225000000;
   localparam logic [FREQ_W-1:0] MOVE_LIMIT = 28'd10000;
   localparam logic [XTAL_W-1:0] XTAL_MIN   = 25'd20000000;
   localparam logic [XTAL_W-1:0] XTAL_RESET = 25'd27000000;
   localparam logic [QDIV_W-1:0] DIV_BY_FOUR = 17'd4;
   localparam logic [P1_W-1:0]   P1_OFFSET  = 18'd512;
   localparam logic [3:0]        MS_DIV4_CODE = 4'b1100;

   // Register map.
   localparam logic [BYTE_W-1:0] PLL_A_BASE  = 8'd26;
   localparam logic [BYTE_W-1:0] PLL_B_BASE  = 8'd34;
   localparam logic [BYTE_W-1:0] MS_BASE     = 8'd42;
   localparam logic [BYTE_W-1:0] RST_ADDR    = 8'd177;
   localparam logic [BYTE_W-1:0] RST_VALUE   = 8'hA0;
   localparam logic [IDX_W-1:0]  IDX_LAST    = 2'd2;

   // Write sequence positions.
   localparam logic [CNT_W-1:0]  WR_LAST_PLAIN = 5'd15;
   localparam logic [CNT_W-1:0]  WR_LAST_RST   = 5'd16;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_VCO,
      ST_RSCALE,
      ST_MUL_VCO,
      ST_DIV_XTAL,
      ST_DIV_FRAC,
      ST_MUL_P2,
      ST_FINISH,
      ST_EMIT
   } csdw_state_type;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } csdw_div_req_type;

   typedef struct packed {
      logic             done;
      logic [DVD_W-1:0] quotient;
      logic [DVS_W-1:0] remainder;
   } csdw_div_rsp_type;

   typedef struct packed {
      logic                start;
      logic [MCAND_W-1:0]  mcand;
      logic [MPLIER_W-1:0] mplier;
   } csdw_mul_req_type;

   typedef struct packed {
      logic               done;
      logic [MCAND_W-1:0] product;
   } csdw_mul_rsp_type;

endpackage

`default_nettype wire

// ===== sv/clock_synth_divider_writer_unit.sv =====
// Divider writer for a fractional-N clock synthesizer.
// A request on req_* (valid/ready) carries an output number and a target
// frequency in Hz. The block answers on rsp_* (valid/ready) with 16 register
// writes, PLL bytes and then multisynth bytes, plus a soft PLL reset write
// when one is due; rsp_last_write marks the final write of the request.
// csr_write_enable loads the crystal frequency register, with no wait.
// One request is worked on at a time. Before the first write the block runs
// three passes of the bit-serial divider, two passes of the shift-add
// multiplier, R-divider scaling, the reset decision and the load of the
// first write. The writes then leave at one per cycle, as long as the
// receiver keeps rsp_ready high.
// When the receiver holds rsp_ready low, the current write stays on the
// ports unchanged and the sequence pauses. req_ready rises again once the
// last write of the request sits in the output register.
// Synchronous reset returns the block to idle, drops any pending write,
// sets the crystal to 27 MHz and clears the stored reset frequency.
`default_nettype none

module clock_synth_divider_writer_unit import csdw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [IDX_W-1:0]  req_output_index,
   input  logic [FREQ_W-1:0] req_target_freq,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [BYTE_W-1:0] rsp_reg_addr,
   output logic [BYTE_W-1:0] rsp_reg_value,
   output logic              rsp_last_write,
   input  logic              csr_write_enable,
   input  logic [XTAL_W-1:0] csr_write_data
);

   csdw_state_type      state_ff, state_in;
   logic                launch_ff, launch_in;
   logic [XTAL_W-1:0]   xtal_cfg_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic [FREQ_W-1:0]   freq_ff;
   logic [XTAL_W-1:0]   xtal_ff;
   logic [QDIV_W-1:0]   div_ff;
   logic [RSH_W-1:0]    rsh_ff;
   logic [DVD_W-1:0]    fvco_ff;
   logic [A_W-1:0]      a_ff;
   logic [C_W-1:0]      b_ff;
   logic [F_W-1:0]      f_ff;
   logic [P1_W-1:0]     p1_ff;
   logic [P2_W-1:0]     p2_ff;
   logic                do_reset_ff;
   logic [FREQ_W-1:0]   last_reset_freq_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic                rsp_valid_ff;
   logic [BYTE_W-1:0]   rsp_addr_ff;
   logic [BYTE_W-1:0]   rsp_value_ff;
   logic                rsp_last_ff;

   csdw_div_req_type    div_req;
   csdw_div_rsp_type    div_rsp;
   csdw_mul_req_type    mul_req;
   csdw_mul_rsp_type    mul_rsp;

   logic                load_out;
   logic                last_sel;
   logic [FREQ_W-1:0]   freq_clamped;
   logic [XTAL_W-1:0]   xtal_clamped;
   logic [IDX_W-1:0]    idx_clamped;
   logic [C_W-1:0]      c_val;
   logic [P1_W-1:0]     ms_p1;
   logic                div_is_four;
   logic [FREQ_W-1:0]   move_dist;
   logic                at_vco_limit;
   logic [BYTE_W-1:0]   pll_base;
   logic [BYTE_W-1:0]   ms_base;
   logic [BYTE_W-1:0]   sel_addr;
   logic [BYTE_W-1:0]   sel_value;

   csdw_sdiv u_sdiv (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   csdw_smul u_smul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   // Request clamping.
   always_comb begin
      if (req_target_freq < FREQ_MIN) begin
         freq_clamped = FREQ_MIN;
      end else if (req_target_freq > FREQ_MAX) begin
         freq_clamped = FREQ_MAX;
      end else begin
         freq_clamped = req_target_freq;
      end
      xtal_clamped = (xtal_cfg_ff < XTAL_MIN) ? XTAL_MIN : xtal_cfg_ff;
      idx_clamped  = (req_output_index > IDX_LAST) ? IDX_LAST : req_output_index;
   end

   // Derived values used by the reset decision, the write bytes and the unit operands.
   always_comb begin
      c_val        = xtal_ff[XTAL_W-1:FRAC_SH];
      ms_p1        = P1_W'({div_ff[MPLIER_W-1:0], 7'b0}) - P1_OFFSET;
      div_is_four  = (div_ff == DIV_BY_FOUR);
      move_dist    = (last_reset_freq_ff > freq_ff) ? (last_reset_freq_ff - freq_ff)
                                                    : (freq_ff - last_reset_freq_ff);
      at_vco_limit = ({1'b0, fvco_ff[DVD_W-1:3]} <= freq_ff);
      pll_base     = (idx_ff != '0) ? PLL_B_BASE : PLL_A_BASE;
      ms_base      = MS_BASE + {3'b0, idx_ff, 3'b0};
      last_sel     = (cnt_ff == (do_reset_ff ? WR_LAST_RST : WR_LAST_PLAIN));
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DIV_VCO;
         end
         ST_DIV_VCO: begin
            if (div_rsp.done) state_in = ST_RSCALE;
         end
         ST_RSCALE: begin
            if (div_ff <= DIV_MAX) state_in = ST_MUL_VCO;
         end
         ST_MUL_VCO: begin
            if (mul_rsp.done) state_in = ST_DIV_XTAL;
         end
         ST_DIV_XTAL: begin
            if (div_rsp.done) state_in = ST_DIV_FRAC;
         end
         ST_DIV_FRAC: begin
            if (div_rsp.done) state_in = ST_MUL_P2;
         end
         ST_MUL_P2: begin
            if (mul_rsp.done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (load_out && last_sel) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      launch_in = (state_in != state_ff);
   end

   // Outputs of the sequencer: handshakes and operands of the shared units.
   always_comb begin
      req_ready        = (state_ff == ST_IDLE);
      load_out         = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);
      div_req.start    = launch_ff && (state_ff inside {ST_DIV_VCO, ST_DIV_XTAL, ST_DIV_FRAC});
      mul_req.start    = launch_ff && (state_ff inside {ST_MUL_VCO, ST_MUL_P2});
      div_req.dividend = VCO_MAX_HZ;
      div_req.divisor  = freq_ff;
      mul_req.mcand    = MCAND_W'(freq_ff);
      mul_req.mplier   = div_ff[MPLIER_W-1:0];
      case (state_ff)
         ST_DIV_XTAL: begin
            div_req.dividend = fvco_ff;
            div_req.divisor  = DVS_W'(xtal_ff);
         end
         ST_DIV_FRAC: begin
            div_req.dividend = DVD_W'({b_ff, 7'b0});
            div_req.divisor  = DVS_W'(c_val);
         end
         ST_MUL_P2: begin
            mul_req.mcand  = MCAND_W'(c_val);
            mul_req.mplier = MPLIER_W'(f_ff);
         end
         default: begin
         end
      endcase
   end

   // Byte selection for the write sequence.
   always_comb begin
      if (cnt_ff[CNT_W-1]) begin
         sel_addr = RST_ADDR;
      end else if (cnt_ff[3]) begin
         sel_addr = ms_base + {5'b0, cnt_ff[2:0]};
      end else begin
         sel_addr = pll_base + {5'b0, cnt_ff[2:0]};
      end
      case (cnt_ff)
         5'd0:    sel_value = c_val[15:8];
         5'd1:    sel_value = c_val[7:0];
         5'd2:    sel_value = {6'b0, p1_ff[17:16]};
         5'd3:    sel_value = p1_ff[15:8];
         5'd4:    sel_value = p1_ff[7:0];
         5'd5:    sel_value = {c_val[19:16], p2_ff[19:16]};
         5'd6:    sel_value = p2_ff[15:8];
         5'd7:    sel_value = p2_ff[7:0];
         5'd9:    sel_value = 8'd1;
         5'd10:   sel_value = div_is_four ? {1'b0, rsh_ff, MS_DIV4_CODE}
                                          : {1'b0, rsh_ff, 2'b0, ms_p1[17:16]};
         5'd11:   sel_value = div_is_four ? 8'd0 : ms_p1[15:8];
         5'd12:   sel_value = div_is_four ? 8'd0 : ms_p1[7:0];
         5'd16:   sel_value = RST_VALUE;
         default: sel_value = 8'd0;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         launch_ff          <= 1'b0;
         xtal_cfg_ff        <= XTAL_RESET;
         last_reset_freq_ff <= '0;
         do_reset_ff        <= 1'b0;
         cnt_ff             <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff  <= state_in;
         launch_ff <= launch_in;
         if (csr_write_enable) begin
            xtal_cfg_ff <= csr_write_data;
         end
         // Soft reset decision, taken once per request.
         if (state_ff == ST_FINISH) begin
            cnt_ff <= '0;
            if (at_vco_limit) begin
               do_reset_ff <= 1'b1;
            end else if (move_dist > MOVE_LIMIT) begin
               do_reset_ff        <= 1'b1;
               last_reset_freq_ff <= freq_ff;
            end else begin
               do_reset_ff <= 1'b0;
            end
         end else if (load_out) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         // Output register valid.
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Working registers of the calculation.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         idx_ff  <= idx_clamped;
         freq_ff <= freq_clamped;
         xtal_ff <= xtal_clamped;
         rsh_ff  <= '0;
      end
      if (state_ff == ST_DIV_VCO && div_rsp.done) begin
         div_ff <= div_rsp.quotient[QDIV_W-1:0];
      end
      // Halve the divider into the R stage until it fits, then make it even.
      if (state_ff == ST_RSCALE) begin
         if (div_ff > DIV_MAX) begin
            div_ff <= {1'b0, div_ff[QDIV_W-1:1]};
            rsh_ff <= rsh_ff + 1'b1;
         end else begin
            div_ff <= {div_ff[QDIV_W-1:1], 1'b0};
         end
      end
      if (state_ff == ST_MUL_VCO && mul_rsp.done) begin
         fvco_ff <= mul_rsp.product << rsh_ff;
      end
      if (state_ff == ST_DIV_XTAL && div_rsp.done) begin
         a_ff <= div_rsp.quotient[A_W-1:0];
         b_ff <= div_rsp.remainder[XTAL_W-1:FRAC_SH];
      end
      if (state_ff == ST_DIV_FRAC && div_rsp.done) begin
         f_ff <= div_rsp.quotient[F_W-1:0];
      end
      // Feedback terms p1 and p2, kept to the bits the registers carry.
      if (state_ff == ST_MUL_P2 && mul_rsp.done) begin
         p1_ff <= P1_W'({a_ff, 7'b0}) + P1_W'(f_ff) - P1_OFFSET;
         p2_ff <= {b_ff[P2_W-8:0], 7'b0} - mul_rsp.product[P2_W-1:0];
      end
      if (load_out) begin
         rsp_addr_ff  <= sel_addr;
         rsp_value_ff <= sel_value;
         rsp_last_ff  <= last_sel;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_reg_addr   = rsp_addr_ff;
   assign rsp_reg_value  = rsp_value_ff;
   assign rsp_last_write = rsp_last_ff;

endmodule

`default_nettype wire

// ===== sv/csdw_sdiv.sv =====
`default_nettype none

module csdw_sdiv import csdw_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  csdw_div_req_type div_req,
   output csdw_div_rsp_type div_rsp
);

   logic [DVS_W-1:0]     rem_ff, rem_in;
   logic [DVD_W-1:0]     quo_ff, quo_in;
   logic [DVS_W-1:0]     dvs_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [DVS_W:0]       trial;
   logic [DVS_W:0]       diff;
   logic                 fits;

   // One restoring step: bring down the next dividend bit and try the subtract.
   always_comb begin
      trial  = {rem_ff, quo_ff[DVD_W-1]};
      diff   = trial - {1'b0, dvs_ff};
      fits   = (trial >= {1'b0, dvs_ff});
      rem_in = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_in = {quo_ff[DVD_W-2:0], fits};
   end

   // Step control: one bit per cycle, done pulses once after the last bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_W'(DVD_W - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath shift registers.
   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff <= '0;
         quo_ff <= div_req.dividend;
         dvs_ff <= div_req.divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

`default_nettype wire

// ===== sv/csdw_smul.sv =====
`default_nettype none

module csdw_smul import csdw_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  csdw_mul_req_type mul_req,
   output csdw_mul_rsp_type mul_rsp
);

   logic [MCAND_W-1:0]   acc_ff;
   logic [MCAND_W-1:0]   mcand_ff;
   logic [MPLIER_W-1:0]  mplier_ff;
   logic [MUL_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;

   // Step control: one multiplier bit per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (mul_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= MUL_CNT_W'(MPLIER_W - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Shift-and-add: the multiplicand moves left, the multiplier right.
   always_ff @(posedge clock) begin
      if (mul_req.start) begin
         acc_ff    <= '0;
         mcand_ff  <= mul_req.mcand;
         mplier_ff <= mul_req.mplier;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_ff <= acc_ff + mcand_ff;
         end
         mcand_ff  <= {mcand_ff[MCAND_W-2:0], 1'b0};
         mplier_ff <= {1'b0, mplier_ff[MPLIER_W-1:1]};
      end
   end

   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = acc_ff;

endmodule

`default_nettype wire

// ===== sv/csdw_checker.sv =====
`default_nettype none
`include "clock_synth_divider_writer_unit_defines.svh"

module csdw_checker import csdw_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [BYTE_W-1:0] rsp_reg_addr,
   input wire logic [BYTE_W-1:0] rsp_reg_value,
   input wire logic              rsp_last_write
);

   // A stalled write holds its contents.
   `CSDW_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_reg_addr) && $stable(rsp_reg_value) && $stable(rsp_last_write), "stalled write changed")

   // One request at a time: after acceptance the input closes.
   `CSDW_ASSERT_NEXT(a_req_single, req_valid && req_ready, !req_ready, "second request taken while busy")

   // The last write of a request is not followed at once by another write.
   `CSDW_ASSERT_NEXT(a_last_gap, rsp_valid && rsp_ready && rsp_last_write, !rsp_valid, "write directly after final write")

   // The soft reset write has a fixed value and always closes the sequence.
   `CSDW_ASSERT_SAME(a_rst_write, rsp_valid && rsp_reg_addr == RST_ADDR, rsp_reg_value == RST_VALUE && rsp_last_write, "bad soft reset write")

   // While a sequence is still being written, no new request is taken.
   `CSDW_ASSERT_SAME(a_busy_emit, rsp_valid && !rsp_last_write, !req_ready, "ready during write sequence")

endmodule

bind clock_synth_divider_writer_unit csdw_checker u_csdw_checker (.*);

`default_nettype wire
